/* src/mcr_pkg.sv */
// Midpoint circle rasteriser: shared types and constants.
// No dependencies; imported by every module in src.
package mcr_pkg;

	localparam int COORD_W  = 15;
	localparam int RADIUS_W = 13;
	localparam int STEP_W   = 14;
	localparam int ODD_W    = 15;
	localparam int DEC_W    = 16;
	localparam int POINT_W  = 16;
	localparam int IDX_W    = 3;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	localparam logic [IDX_W-1:0] LAST_POINT = 3'd7;
	localparam logic [ODD_W-1:0] ODD_STEP   = 15'd2;
	localparam logic [ODD_W-1:0] ODD_INIT   = 15'd1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [STEP_W-1:0]  step_t;
	typedef logic signed [POINT_W-1:0] point_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// sequencer -> iteration state
	typedef struct packed {
		logic start;
		logic advance;
	} step_ctrl_t;

	// iteration state -> sequencer and point unit
	typedef struct packed {
		logic   running;
		logic   done;
		coord_t center_col;
		coord_t center_row;
		step_t  step_x;
		step_t  step_y;
	} step_stat_t;

endpackage

/* src/midpoint_circle_rasterizer.sv */
// Midpoint circle rasteriser, top level: sequencer, output register, assertions.
// Depends on mcr_pkg, mcr_step_unit and mcr_point_unit.
//
// Outline circle rasteriser using the midpoint scheme. A request with action 0 loads the
// centre and radius and produces no points. A request with action 1 runs one iteration:
// while the circle is unfinished it produces eight points in fixed octant order, flagging
// last_of_step on the eighth and circle_done when that iteration completes the outline;
// otherwise it produces nothing. An iteration emits its points one per cycle while point_stall
// allows, through a single shared coordinate adder pair, and req_stall is held high until the
// eighth point enters the output register, so a new request can be taken on that cycle.
// Load requests and empty iterations do not raise req_stall; point_stall back-pressure holds
// the sequencer. Points on the axes are repeated as the scheme generates them.
module midpoint_circle_rasterizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          action,
	input  mcr_pkg::coord_t               center_x,
	input  mcr_pkg::coord_t               center_y,
	input  logic [mcr_pkg::RADIUS_W-1:0]  radius,
	output logic                          point_valid,
	input  logic                          point_stall,
	output mcr_pkg::point_t               point_x,
	output mcr_pkg::point_t               point_y,
	output logic                          last_of_step,
	output logic                          circle_done
);
	import mcr_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	logic [IDX_W-1:0]  k_q;

	step_ctrl_t        ctrl;
	step_stat_t        stat;
	point_t            col;
	point_t            row;

	logic              req_acc;
	logic              emit_load;
	logic              last_load;

	logic              point_valid_q;
	point_t            point_x_q;
	point_t            point_y_q;
	logic              last_q;
	logic              done_q;

	assign req_acc   = req_valid && !req_stall;
	assign emit_load = (state_q == ST_EMIT) && (!point_valid_q || !point_stall);
	assign last_load = emit_load && (k_q == LAST_POINT);

	// An iteration only starts on a live circle; a step on an idle one is simply dropped.
	assign ctrl.start   = req_acc && (action == ACT_START);
	assign ctrl.advance = req_acc && (action == ACT_STEP) && stat.running;

	mcr_step_unit u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.stat     (stat)
	);

	mcr_point_unit u_point (
		.clk     (clk),
		.capture (ctrl.advance),
		.stat    (stat),
		.idx     (k_q),
		.col     (col),
		.row     (row)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.advance)
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (last_load && !ctrl.advance)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs: busy while points remain, but free on the cycle the last one goes out
	always_comb begin
		unique case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_EMIT: req_stall = !last_load;
			default: req_stall = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_nxt;
			// wraps back to zero after the eighth point
			if (emit_load)
				k_q <= k_q + IDX_W'(1);
		end
	end

	// Output register: decouples the point stream from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			point_valid_q <= 1'b0;
		else if (emit_load)
			point_valid_q <= 1'b1;
		else if (!point_stall)
			point_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			point_x_q <= col;
			point_y_q <= row;
			last_q    <= (k_q == LAST_POINT);
			done_q    <= (k_q == LAST_POINT) && stat.done;
		end
	end

	assign point_valid  = point_valid_q;
	assign point_x      = point_x_q;
	assign point_y      = point_y_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

	a_idx_at_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (k_q == '0))
		else $error("point index not at rest while idle");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && circle_done) |-> last_of_step)
		else $error("circle_done without last_of_step");

	a_advance_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance |=> (state_q == ST_EMIT))
		else $error("iteration accepted but no points scheduled");

	a_no_load_mid_iter: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && !last_load) |-> !ctrl.start)
		else $error("circle reloaded during an iteration");

endmodule

/* src/mcr_step_unit.sv */
// Midpoint circle rasteriser: iteration state and decision update.
// Depends on mcr_pkg. The y move is applied on the advance cycle, the x move in the cycle after it.
module mcr_step_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcr_pkg::step_ctrl_t           ctrl,
	input  mcr_pkg::coord_t               center_x,
	input  mcr_pkg::coord_t               center_y,
	input  logic [mcr_pkg::RADIUS_W-1:0]  radius,
	output mcr_pkg::step_stat_t           stat
);
	import mcr_pkg::*;

	coord_t                    center_col_q;
	coord_t                    center_row_q;
	step_t                     step_x_q;
	step_t                     step_y_q;
	logic [ODD_W-1:0]          odd_x_q;
	logic [ODD_W-1:0]          odd_y_q;
	logic signed [DEC_W-1:0]   decision_q;
	logic [STEP_W-1:0]         twice_radius_q;
	logic                      running_q;
	logic                      fix_q;
	logic                      done_q;

	logic signed [DEC_W-1:0]   dec_after_y;
	logic signed [DEC_W-1:0]   dec_after_x;
	logic signed [DEC_W-1:0]   dec_start;
	logic [ODD_W-1:0]          odd_x_next;
	step_t                     step_x_dec;
	step_t                     step_x_new;
	logic                      x_move;
	logic                      finished;

	assign dec_after_y = decision_q + $signed({1'b0, odd_y_q});
	assign odd_x_next  = odd_x_q + ODD_STEP;
	assign dec_after_x = decision_q + $signed({1'b0, odd_x_next})
	                   - $signed({2'b00, twice_radius_q});
	assign dec_start   = $signed(DEC_W'(1)) - $signed({2'b00, radius, 1'b0});
	assign step_x_dec  = step_x_q - step_t'(1);
	assign x_move      = (decision_q > 0);
	assign step_x_new  = x_move ? step_x_dec : step_x_q;
	assign finished    = (step_x_new < step_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q   <= '0;
			center_row_q   <= '0;
			step_x_q       <= '0;
			step_y_q       <= '0;
			odd_x_q        <= ODD_INIT;
			odd_y_q        <= ODD_INIT;
			decision_q     <= '0;
			twice_radius_q <= '0;
			running_q      <= 1'b0;
			fix_q          <= 1'b0;
			done_q         <= 1'b0;
		end else if (ctrl.start) begin
			center_col_q   <= center_x;
			center_row_q   <= center_y;
			step_x_q       <= $signed({1'b0, radius}) - step_t'(1);
			step_y_q       <= '0;
			odd_x_q        <= ODD_INIT;
			odd_y_q        <= ODD_INIT;
			decision_q     <= dec_start;
			twice_radius_q <= {radius, 1'b0};
			running_q      <= (radius != '0);
			fix_q          <= 1'b0;
			done_q         <= 1'b0;
		end else if (ctrl.advance) begin
			fix_q <= 1'b1;
			if (decision_q <= 0) begin
				step_y_q   <= step_y_q + step_t'(1);
				decision_q <= dec_after_y;
				odd_y_q    <= odd_y_q + ODD_STEP;
			end
		end else if (fix_q) begin
			fix_q     <= 1'b0;
			done_q    <= finished;
			running_q <= !finished;
			if (x_move) begin
				step_x_q   <= step_x_dec;
				odd_x_q    <= odd_x_next;
				decision_q <= dec_after_x;
			end
		end
	end

	assign stat.running    = running_q;
	assign stat.done       = done_q;
	assign stat.center_col = center_col_q;
	assign stat.center_row = center_row_q;
	assign stat.step_x     = step_x_q;
	assign stat.step_y     = step_y_q;

endmodule

/* src/mcr_point_unit.sv */
// Midpoint circle rasteriser: shared coordinate adder pair.
// Depends on mcr_pkg. Holds one iteration's centre and offsets, forms one octant point per index.
module mcr_point_unit (
	input  logic                       clk,
	input  logic                       capture,
	input  mcr_pkg::step_stat_t        stat,
	input  logic [mcr_pkg::IDX_W-1:0]  idx,
	output mcr_pkg::point_t            col,
	output mcr_pkg::point_t            row
);
	import mcr_pkg::*;

	coord_t cx_q;
	coord_t cy_q;
	step_t  x_q;
	step_t  y_q;

	point_t a_term;
	point_t b_term;
	point_t cx_ext;
	point_t cy_ext;

	always_ff @(posedge clk) begin
		if (capture) begin
			cx_q <= stat.center_col;
			cy_q <= stat.center_row;
			x_q  <= stat.step_x;
			y_q  <= stat.step_y;
		end
	end

	// idx[2] swaps the octant, idx[1] negates the column term, idx[0] picks the row sign
	assign a_term = idx[2] ? POINT_W'(y_q) : POINT_W'(x_q);
	assign b_term = idx[2] ? POINT_W'(x_q) : POINT_W'(y_q);
	assign cx_ext = POINT_W'(cx_q);
	assign cy_ext = POINT_W'(cy_q);
	assign col    = idx[1] ? (cx_ext - a_term) : (cx_ext + a_term);
	assign row    = idx[0] ? (cy_ext + b_term) : (cy_ext - b_term);

endmodule
